// ----- rtl/tkcl_pkg.sv -----
// ----------------------------------------------------------------------------
// tkcl_pkg
// Shared types and constants for the two-key combination lock.
// ----------------------------------------------------------------------------
`default_nettype none

package tkcl_pkg;

  // Debounce history length in poll samples.
  localparam int unsigned DEBOUNCE_SAMPLES = 8;

  localparam int unsigned CODE_W    = 8;
  localparam int unsigned COUNT_W   = 3;
  localparam int unsigned TICK_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 8;

  // Code registers restart at binary 11.
  localparam logic [CODE_W-1:0]  CODE_START     = 8'd3;
  localparam logic [TICK_W-1:0]  TIMEOUT_RESET  = 8'd16;
  localparam logic [COUNT_W-1:0] CODE_LEN_RESET = 3'd6;
  localparam logic [TICK_W-1:0]  TICK_MAX       = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT_TICKS = 1'b0,
    CFG_CODE_LENGTH   = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_ENTRY    = 3'd1,
    EV_LOCKED   = 3'd2,
    EV_UNLOCKED = 3'd3,
    EV_WRONG    = 3'd4,
    EV_TIMEOUT  = 3'd5
  } lock_event_e;

  // Result word, is_locked in the lowest bit.
  typedef struct packed {
    lock_event_e        event_res;
    logic [COUNT_W-1:0] entries_made;
    logic               key_held;
    logic               is_locked;
  } result_t;

  // One accepted input item.
  typedef struct packed {
    logic op;
    logic key_one_down;
    logic key_zero_down;
  } item_t;

endpackage : tkcl_pkg

`default_nettype wire

// ----- rtl/tkcl_core.sv -----
// ----------------------------------------------------------------------------
// tkcl_core
// Lock state registers and the per-item update (debounce, code entry,
// compare, timeout).
// ----------------------------------------------------------------------------
`default_nettype none

module tkcl_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      step_i,
  input  wire tkcl_pkg::item_t           item_i,
  input  wire logic [tkcl_pkg::TICK_W-1:0]  timeout_ticks_i,
  input  wire logic [tkcl_pkg::COUNT_W-1:0] code_length_i,
  output tkcl_pkg::result_t              result_o
);
  import tkcl_pkg::*;

  logic [DEBOUNCE_SAMPLES-1:0] hist_q, hist_d;
  logic                        press_q, press_d;
  logic                        bit_q, bit_d;
  logic [CODE_W-1:0]           stored_q, stored_d;
  logic [CODE_W-1:0]           attempt_q, attempt_d;
  logic [COUNT_W-1:0]          count_q, count_d;
  logic [TICK_W-1:0]           idle_q, idle_d;
  logic                        await_q, await_d;
  logic                        locked_q, locked_d;
  lock_event_e                 ev;

  logic [DEBOUNCE_SAMPLES-1:0] hist_n;
  logic [CODE_W-1:0]           stored_sh, attempt_sh;
  logic [COUNT_W-1:0]          count_inc, len;
  logic [TICK_W-1:0]           idle_inc;

  always_comb begin
    hist_n     = {hist_q[DEBOUNCE_SAMPLES-2:0], item_i.key_zero_down | item_i.key_one_down};
    stored_sh  = {stored_q[CODE_W-2:0], bit_q};
    attempt_sh = {attempt_q[CODE_W-2:0], bit_q};
    count_inc  = count_q + COUNT_W'(1);
    len        = (code_length_i == '0) ? COUNT_W'(1) : code_length_i;
    idle_inc   = (idle_q == TICK_MAX) ? TICK_MAX : idle_q + TICK_W'(1);

    hist_d    = hist_q;
    press_d   = press_q;
    bit_d     = bit_q;
    stored_d  = stored_q;
    attempt_d = attempt_q;
    count_d   = count_q;
    idle_d    = idle_q;
    await_d   = await_q;
    locked_d  = locked_q;
    ev        = EV_NONE;

    if (item_i.op) begin
      // timer tick
      if (await_q) begin
        if (idle_inc < timeout_ticks_i) begin
          idle_d = idle_inc;
        end else begin
          idle_d  = '0;
          await_d = 1'b0;
          count_d = '0;
          if (locked_q) begin
            attempt_d = CODE_START;
          end else begin
            stored_d = CODE_START;
          end
          ev = EV_TIMEOUT;
        end
      end
    end else begin
      hist_d = hist_n;
      if (&hist_n) begin
        press_d = 1'b1;
        if (item_i.key_one_down) begin
          bit_d = 1'b1;
        end
      end else if (hist_n == '0 && press_q) begin
        // debounced release: take one code bit
        if (locked_q) begin
          attempt_d = attempt_sh;
        end else begin
          stored_d = stored_sh;
        end
        press_d = 1'b0;
        bit_d   = 1'b0;
        idle_d  = '0;
        if (count_inc < len) begin
          count_d = count_inc;
          await_d = 1'b1;
          ev      = EV_ENTRY;
        end else begin
          count_d = '0;
          await_d = 1'b0;
          if (!locked_q) begin
            locked_d  = 1'b1;
            attempt_d = CODE_START;
            ev        = EV_LOCKED;
          end else if (attempt_sh == stored_q) begin
            locked_d = 1'b0;
            stored_d = CODE_START;
            ev       = EV_UNLOCKED;
          end else begin
            attempt_d = CODE_START;
            ev        = EV_WRONG;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q    <= '0;
      press_q   <= 1'b0;
      bit_q     <= 1'b0;
      stored_q  <= CODE_START;
      attempt_q <= CODE_START;
      count_q   <= '0;
      idle_q    <= '0;
      await_q   <= 1'b0;
      locked_q  <= 1'b0;
    end else if (step_i) begin
      hist_q    <= hist_d;
      press_q   <= press_d;
      bit_q     <= bit_d;
      stored_q  <= stored_d;
      attempt_q <= attempt_d;
      count_q   <= count_d;
      idle_q    <= idle_d;
      await_q   <= await_d;
      locked_q  <= locked_d;
    end
  end

  always_comb begin
    result_o.is_locked    = locked_d;
    result_o.key_held     = press_d;
    result_o.entries_made = count_d;
    result_o.event_res    = ev;
  end

endmodule : tkcl_core

`default_nettype wire

// ----- rtl/two_key_combination_lock.sv -----
// ----------------------------------------------------------------------------
// two_key_combination_lock
// Debounced two-key code entry with lock, unlock, wrong-code and timeout.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries poll samples (tuser = 0, tdata = key states) and timer
//    ticks (tuser = 1, key bits ignored). One result per item on m_axis.
//  - cfg channel writes timeout_ticks (index 0) and code_length (index 1).
//    It is always ready; write only while no transaction is in flight.
//  - An item taken into the input register passes the state update into the
//    result register, which drives m_axis. Throughput is one item per cycle
//    while m_axis does not stall, set by both registers and the state update.
//  - When m_axis stalls, the result register holds and the input register
//    still takes one more item; s_axis_tready drops only while both are full.
//  - Reset clears both pipeline registers, debounce history and counters;
//    code registers return to binary 11, mode to unlocked, timeout_ticks to
//    16 and code_length to 6.
// ----------------------------------------------------------------------------
`default_nettype none

module two_key_combination_lock (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // poll/tick stream
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [0] key_zero_down, [1] key_one_down
  input  wire logic [0:0] s_axis_tuser,   // [0] op
  // result stream
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [0] is_locked, [1] key_held,
                                          // [4:2] entries_made, [7:5] event_res
  // register writes
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [tkcl_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  wire logic [tkcl_pkg::CFG_DAT_W-1:0]    cfg_data_i
);
  import tkcl_pkg::*;

  // config registers
  logic [TICK_W-1:0]  timeout_q;
  logic [COUNT_W-1:0] code_len_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q  <= TIMEOUT_RESET;
      code_len_q <= CODE_LEN_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_TIMEOUT_TICKS: timeout_q  <= cfg_data_i[TICK_W-1:0];
        CFG_CODE_LENGTH:   code_len_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic    in_valid_q;
  item_t   in_item_q;
  logic    step;
  result_t res;
  logic    out_valid_q;
  result_t out_res_q;

  // the item moves into the result register when that slot is free
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.op            <= s_axis_tuser[0];
      in_item_q.key_zero_down <= s_axis_tdata[0];
      in_item_q.key_one_down  <= s_axis_tdata[1];
    end
  end

  tkcl_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .item_i         (in_item_q),
    .timeout_ticks_i(timeout_q),
    .code_length_i  (code_len_q),
    .result_o       (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_step_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> m_axis_tvalid)
    else $error("state update without a result");

  a_locked_event : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_res_q.event_res == EV_LOCKED) |->
      (out_res_q.is_locked && out_res_q.entries_made == '0))
    else $error("lock event with wrong state");

  a_unlocked_event : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_res_q.event_res == EV_UNLOCKED) |->
      (!out_res_q.is_locked && out_res_q.entries_made == '0))
    else $error("unlock event with wrong state");

  a_timeout_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_res_q.event_res == EV_TIMEOUT) |->
      (out_res_q.entries_made == '0))
    else $error("timeout left a partial entry");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !step)
    else $error("result overwritten while stalled");

endmodule : two_key_combination_lock

`default_nettype wire

// ----- bench/two_key_combination_lock_tb.sv -----
// ----------------------------------------------------------------------------
// two_key_combination_lock_tb
// Self-checking bench for the two-key combination lock. A short table of
// directed polls, ticks and register writes comes first. Random phases follow,
// built mostly from debounced key entries and whole codes, with some noise.
// Every result transaction is checked against a cycle-free predictor.
// ----------------------------------------------------------------------------

module two_key_combination_lock_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import tkcl_pkg::*;

  // Cycles with no transaction on any channel before the run is abandoned.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Settle time after the last result: result register plus margin.
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned NUM_PHASES     = 8;
  localparam int unsigned PHASE_ITEMS    = 40;
  localparam int unsigned MAX_PRINTS     = 20;

  // --------------------------------------------------------------------------
  // DUT signals, the bench-driven ones at known values from time zero
  // --------------------------------------------------------------------------
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;
  logic [0:0]           s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_addr_i    = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i    = '0;

  two_key_combination_lock uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [0] key_zero_down, [1] key_one_down
    .s_axis_tuser  (s_axis_tuser),   // [0] op
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [0] is_locked, [1] key_held,
                                     // [4:2] entries_made, [7:5] event_res
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 20 ns period
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the lock and its registers
  // --------------------------------------------------------------------------
  logic [DEBOUNCE_SAMPLES-1:0] key_history        = '0;
  logic                        press_latched      = 1'b0;
  logic                        one_in_press       = 1'b0;
  logic [CODE_W-1:0]           set_code           = CODE_START;
  logic [CODE_W-1:0]           try_code           = CODE_START;
  logic [COUNT_W-1:0]          entries_so_far     = '0;
  logic [TICK_W-1:0]           ticks_since_release = '0;
  logic                        timeout_armed      = 1'b0;
  logic                        in_locked_mode     = 1'b0;
  logic [TICK_W-1:0]           timeout_setting    = TIMEOUT_RESET;
  logic [COUNT_W-1:0]          length_setting     = CODE_LEN_RESET;

  // Results still owed by the DUT, oldest first.
  result_t expected_results [$];

  // Bench bookkeeping
  int unsigned mismatches     = 0;
  int unsigned results_checked = 0;
  int unsigned sent_items     = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned event_tally [0:7];
  int unsigned src_gap_pct    = 0;   // chance per item of a source gap
  int unsigned sink_stall_pct = 0;   // chance per cycle of a sink stall
  result_t     seen_result;
  result_t     oldest_expected;

  // Directed table row: either a register pair write or a repeated item.
  typedef struct packed {
    logic               is_cfg;
    logic [TICK_W-1:0]  timeout_v;
    logic [COUNT_W-1:0] length_v;
    item_t              item;
    logic [4:0]         reps;
    logic               typed;       // want holds a hand-written result
    result_t            want;        // applies to the last repetition
  } plan_row_t;

  plan_row_t stim_plan [$];

  // --------------------------------------------------------------------------
  // Predictor: one accepted item in, one result out
  // --------------------------------------------------------------------------
  function automatic result_t advance_lock(input item_t it);
    result_t            r;
    lock_event_e        ev;
    logic [COUNT_W-1:0] len;
    ev = EV_NONE;
    if (it.op) begin
      // tick: key fields ignored, counts only after a release
      if (timeout_armed) begin
        if (ticks_since_release != TICK_MAX)
          ticks_since_release = ticks_since_release + 1'b1;
        if (ticks_since_release >= timeout_setting) begin
          ticks_since_release = '0;
          timeout_armed       = 1'b0;
          entries_so_far      = '0;
          if (in_locked_mode)
            try_code = CODE_START;
          else
            set_code = CODE_START;
          ev = EV_TIMEOUT;
        end
      end
    end else begin
      key_history = {key_history[DEBOUNCE_SAMPLES-2:0],
                     it.key_zero_down | it.key_one_down};
      if (&key_history) begin
        press_latched = 1'b1;
        if (it.key_one_down)
          one_in_press = 1'b1;
      end else if (key_history == '0 && press_latched) begin
        // debounced release: shift one bit into the active code
        if (in_locked_mode)
          try_code = {try_code[CODE_W-2:0], one_in_press};
        else
          set_code = {set_code[CODE_W-2:0], one_in_press};
        press_latched       = 1'b0;
        one_in_press        = 1'b0;
        entries_so_far      = entries_so_far + 1'b1;
        ticks_since_release = '0;
        timeout_armed       = 1'b1;
        len = (length_setting == '0) ? COUNT_W'(1) : length_setting;
        if (entries_so_far < len) begin
          ev = EV_ENTRY;
        end else begin
          // code complete, also when the length was lowered mid-entry
          entries_so_far      = '0;
          ticks_since_release = '0;
          timeout_armed       = 1'b0;
          if (!in_locked_mode) begin
            in_locked_mode = 1'b1;
            try_code       = CODE_START;
            ev             = EV_LOCKED;
          end else if (try_code == set_code) begin
            in_locked_mode = 1'b0;
            set_code       = CODE_START;
            ev             = EV_UNLOCKED;
          end else begin
            try_code = CODE_START;
            ev       = EV_WRONG;
          end
        end
      end
    end
    r.is_locked    = in_locked_mode;
    r.key_held     = press_latched;
    r.entries_made = entries_so_far;
    r.event_res    = ev;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("[%0t] mismatch on %s: got %0d, want %0d (result %0d)",
               $realtime, what, got, want, results_checked);
  endtask

  // Each result transaction is compared with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_result = result_t'(m_axis_tdata);
      if (expected_results.size() == 0) begin
        flag_mismatch("unexpected result", 32'(m_axis_tdata), 0);
      end else begin
        oldest_expected = expected_results.pop_front();
        results_checked++;
        event_tally[oldest_expected.event_res]++;
        if (seen_result.is_locked != oldest_expected.is_locked)
          flag_mismatch("is_locked", 32'(seen_result.is_locked),
                        32'(oldest_expected.is_locked));
        if (seen_result.key_held != oldest_expected.key_held)
          flag_mismatch("key_held", 32'(seen_result.key_held),
                        32'(oldest_expected.key_held));
        if (seen_result.entries_made != oldest_expected.entries_made)
          flag_mismatch("entries_made", 32'(seen_result.entries_made),
                        32'(oldest_expected.entries_made));
        if (seen_result.event_res != oldest_expected.event_res)
          flag_mismatch("event_res", 32'(seen_result.event_res),
                        32'(oldest_expected.event_res));
      end
    end
  end

  // Watchdog: any transaction on any channel restarts the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                 quiet_cycles, expected_results.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Sink backpressure: random stall bursts of random length.
  always begin
    @(posedge clk_i);
    if (rst_ni && ($urandom_range(1, 100) <= sink_stall_pct)) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    m_axis_tready <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Source side
  // --------------------------------------------------------------------------
  function automatic item_t mk_item(input logic op, input logic zd, input logic od);
    item_t it;
    it.op            = op;
    it.key_zero_down = zd;
    it.key_one_down  = od;
    return it;
  endfunction

  // Present one item and hold it until the transaction; tvalid stays high.
  task automatic send_item(input item_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, it.key_one_down, it.key_zero_down};
    s_axis_tuser  <= it.op;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(advance_lock(it));
    sent_items++;
  endtask

  // Occasional source gap of random length.
  task automatic idle_source();
    if ($urandom_range(1, 100) <= src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic feed(input logic op, input logic zd, input logic od);
    send_item(mk_item(op, zd, od));
    idle_source();
  endtask

  task automatic send_tick();
    feed(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // Stop sending and wait until every owed result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers back to back; only called while drained.
  task automatic set_regs(input logic [TICK_W-1:0] timeout_v,
                          input logic [COUNT_W-1:0] length_v);
    logic [CFG_DAT_W-COUNT_W-1:0] junk;
    junk = (CFG_DAT_W-COUNT_W)'($urandom);   // upper data bits are don't-care
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= CFG_TIMEOUT_TICKS;
    cfg_data_i  <= timeout_v;
    do @(posedge clk_i); while (!cfg_ready_o);
    timeout_setting = timeout_v;
    cfg_addr_i <= CFG_CODE_LENGTH;
    cfg_data_i <= {junk, length_v};
    do @(posedge clk_i); while (!cfg_ready_o);
    length_setting = length_v;
    cfg_valid_i <= 1'b0;
  endtask

  // One debounced key entry: optional bounce, hold, release.
  task automatic enter_key(input logic one_bit);
    int unsigned k;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 6))
        feed(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    for (k = 0; k < $urandom_range(8, 12); k++) begin
      if ($urandom_range(0, 7) == 0)
        send_tick();
      if (one_bit)
        feed(1'b0, 1'($urandom_range(0, 1)), 1'b1);
      else
        feed(1'b0, 1'b1, 1'b0);
    end
    for (k = 0; k < $urandom_range(8, 10); k++) begin
      if ($urandom_range(0, 7) == 0)
        send_tick();
      feed(1'b0, 1'b0, 1'b0);
    end
  endtask

  // Enough entries to finish the current code. While locked, most codes
  // replay the stored bits so that unlocks actually happen.
  task automatic enter_code();
    int          len;
    int          idx;
    int          need;
    bit          aim;
    logic        b;
    len  = (length_setting == '0) ? 1 : int'(length_setting);
    aim  = in_locked_mode && ($urandom_range(0, 3) != 0);
    need = (int'(entries_so_far) >= len) ? 1 : len - int'(entries_so_far);
    repeat (need) begin
      idx = len - 1 - int'(entries_so_far);
      if (aim && idx >= 0)
        b = set_code[idx[2:0]];
      else
        b = 1'($urandom_range(0, 1));
      enter_key(b);
      // ticks after the release; now and then enough to time out
      if ($urandom_range(0, 11) == 0)
        repeat ((timeout_setting == '0) ? 1 : int'(timeout_setting)) send_tick();
      else
        repeat ($urandom_range(0, 2)) send_tick();
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  function automatic plan_row_t stim_row(input logic op, input logic zd,
                                         input logic od, input int reps);
    plan_row_t row;
    row        = '0;
    row.item   = mk_item(op, zd, od);
    row.reps   = 5'(reps);
    return row;
  endfunction

  function automatic plan_row_t known_row(input logic op, input logic zd,
                                          input logic od, input int reps,
                                          input logic lck, input logic held,
                                          input int cnt, input lock_event_e ev);
    plan_row_t row;
    row                   = stim_row(op, zd, od, reps);
    row.typed             = 1'b1;
    row.want.is_locked    = lck;
    row.want.key_held     = held;
    row.want.entries_made = COUNT_W'(cnt);
    row.want.event_res    = ev;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [TICK_W-1:0] timeout_v,
                                        input logic [COUNT_W-1:0] length_v);
    plan_row_t row;
    row           = '0;
    row.is_cfg    = 1'b1;
    row.timeout_v = timeout_v;
    row.length_v  = length_v;
    return row;
  endfunction

  task automatic build_plan();
    // reset settings: timeout 16, code length 6
    stim_plan.push_back(known_row(1, 0, 0,  1, 0, 0, 0, EV_NONE));    // tick, idle
    stim_plan.push_back(known_row(1, 1, 1,  1, 0, 0, 0, EV_NONE));    // tick ignores keys
    stim_plan.push_back(stim_row (0, 0, 1,  7));                      // one short of a press
    stim_plan.push_back(known_row(0, 0, 0,  8, 0, 0, 0, EV_NONE));    // release w/o press
    stim_plan.push_back(known_row(0, 0, 1,  8, 0, 1, 0, EV_NONE));    // press, one-key
    stim_plan.push_back(stim_row (0, 1, 1,  3));                      // both keys held
    stim_plan.push_back(known_row(0, 0, 0,  8, 0, 0, 1, EV_ENTRY));   // first entry
    stim_plan.push_back(stim_row (1, 0, 0, 15));                      // ticks below timeout
    stim_plan.push_back(known_row(1, 0, 0,  1, 0, 0, 0, EV_TIMEOUT)); // 16th tick
    stim_plan.push_back(known_row(1, 1, 0,  1, 0, 0, 0, EV_NONE));    // timer disarmed
    // zero length acts as one; zero timeout
    stim_plan.push_back(cfg_row(8'd0, 3'd0));
    stim_plan.push_back(stim_row (0, 1, 0,  8));
    stim_plan.push_back(known_row(0, 0, 0,  8, 1, 0, 0, EV_LOCKED));  // code 0 set
    stim_plan.push_back(stim_row (0, 0, 1,  8));
    stim_plan.push_back(known_row(0, 0, 0,  8, 1, 0, 0, EV_WRONG));   // tried 1
    stim_plan.push_back(stim_row (0, 1, 0,  8));
    stim_plan.push_back(known_row(0, 0, 0,  8, 0, 0, 0, EV_UNLOCKED));// tried 0
    // upper extremes
    stim_plan.push_back(cfg_row(8'd255, 3'd7));
    stim_plan.push_back(stim_row (0, 1, 1,  9));
    stim_plan.push_back(known_row(0, 0, 0,  8, 0, 0, 1, EV_ENTRY));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned i;
    int unsigned k;
    int unsigned phase;
    int unsigned phase_end;
    bit          paused;
    logic [TICK_W-1:0]  t_sel;
    logic [COUNT_W-1:0] l_sel;

    for (i = 0; i < 8; i++)
      event_tally[i] = 0;

    // single reset
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part with light idling
    src_gap_pct    = 10;
    sink_stall_pct = 5;
    build_plan();
    for (i = 0; i < stim_plan.size(); i++) begin
      if (stim_plan[i].is_cfg) begin
        drain_results();
        set_regs(stim_plan[i].timeout_v, stim_plan[i].length_v);
      end else begin
        for (k = 0; k < stim_plan[i].reps; k++) begin
          send_item(stim_plan[i].item);
          if (stim_plan[i].typed && k == stim_plan[i].reps - 1)
            expected_results[expected_results.size() - 1] = stim_plan[i].want;
          idle_source();
        end
      end
    end

    // random phases, each with its own register settings, most with random idling
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       begin t_sel = 8'd1;                          l_sel = 3'd1; end
        1:       begin t_sel = 8'd255;                        l_sel = 3'd6; end
        2:       begin t_sel = 8'd0;                          l_sel = 3'd0; end
        3:       begin t_sel = 8'd2;                          l_sel = 3'd7; end
        4:       begin t_sel = TICK_W'($urandom_range(1, 20)); l_sel = 3'd2; end
        5:       begin t_sel = TICK_W'($urandom_range(3, 40)); l_sel = 3'd3; end
        6:       begin t_sel = 8'd16;                         l_sel = 3'd4; end
        default: begin t_sel = TICK_W'($urandom_range(1, 8)); l_sel = 3'd5; end
      endcase
      // a lowered length may land mid-entry: entries carry over the write
      drain_results();
      set_regs(t_sel, l_sel);

      if (phase == NUM_PHASES - 1 || phase == 1 || phase == 4) begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
      end else begin
        src_gap_pct    = $urandom_range(5, 30);
        sink_stall_pct = $urandom_range(2, 12);
      end

      // long timeout: one deliberate expiry at 255 ticks
      if (phase == 1) begin
        enter_key(1'($urandom_range(0, 1)));
        repeat (int'(timeout_setting)) send_tick();
      end

      paused    = 1'b0;
      phase_end = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end) begin
        if ($urandom_range(0, 9) < 2)
          repeat ($urandom_range(1, 12))
            feed(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
        else
          enter_code();
        // hold off the source until everything owed has come back
        if (!paused && phase != NUM_PHASES - 1 && sent_items + PHASE_ITEMS / 2 >= phase_end) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end

    drain_results();

    $display("Covered %0d items over %0d random phases, %0d results checked.",
             sent_items, NUM_PHASES, results_checked);
    $display("Events: %0d entries, %0d locks, %0d unlocks, %0d wrong codes, %0d timeouts.",
             event_tally[EV_ENTRY], event_tally[EV_LOCKED], event_tally[EV_UNLOCKED],
             event_tally[EV_WRONG], event_tally[EV_TIMEOUT]);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule : two_key_combination_lock_tb
